FILE: hw/rtl/pps_pkg.sv
// Shared types and codes for the preemptive priority scheduler.
// Request and result payloads, job cell contents and chain controls.
// No dependencies.
package pps_pkg;

    localparam int MAX_JOBS_DEF = 32;

    localparam logic       MODE_ARRIVAL = 1'b0;
    localparam logic       MODE_TICK    = 1'b1;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_REJECTED = 2'd1;
    localparam logic [1:0] ST_SERVED   = 2'd2;
    localparam logic [1:0] ST_IDLE     = 2'd3;

    typedef struct packed {
        logic        mode;
        logic [5:0]  job_number;
        logic [15:0] job_burst;
        logic [7:0]  job_priority;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  served_job;
        logic        job_done;
        logic [31:0] finish_time;
        logic [31:0] turnaround_time;
        logic [31:0] wait_time;
    } t_res;

    // Job held in a cell; due is arrival plus original burst.
    typedef struct packed {
        logic [7:0]  prio;
        logic [5:0]  job;
        logic [15:0] remaining;
        logic [31:0] arrival;
        logic [31:0] due;
    } t_job;

    typedef struct packed {
        logic ins;
        logic pop;
        logic dec;
    } t_chain_op;

endpackage

FILE: hw/rtl/pps_job_cell.sv
// One cell of the job chain, kept sorted by priority, job number and slot.
// Depends on pps_pkg for the job and chain control types.
module pps_job_cell #(
    parameter int SW = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pps_pkg::t_chain_op i_op,
    input  pps_pkg::t_job      i_new,
    input  logic [SW-1:0]      i_new_slot,
    input  pps_pkg::t_job      i_prev,
    input  logic [SW-1:0]      i_prev_slot,
    input  logic               i_prev_valid,
    input  logic               i_prev_less,
    input  pps_pkg::t_job      i_next,
    input  logic [SW-1:0]      i_next_slot,
    input  logic               i_next_valid,
    output pps_pkg::t_job      o_ent,
    output logic [SW-1:0]      o_slot,
    output logic               o_valid,
    output logic               o_less
);
    import pps_pkg::*;

    logic          r_valid;
    t_job          r_ent;
    logic [SW-1:0] r_slot;

    // New request sorts ahead of this cell, or this cell is empty.
    assign o_less = !r_valid ||
        ({i_new.prio, i_new.job, i_new_slot} < {r_ent.prio, r_ent.job, r_slot});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.pop) begin
            r_valid <= i_next_valid;
        end else if (i_op.ins && o_less) begin
            r_valid <= i_prev_less ? i_prev_valid : 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.pop) begin
            r_ent  <= i_next;
            r_slot <= i_next_slot;
        end else if (i_op.ins && o_less) begin
            // shift down from the neighbor, or take the new job at the boundary
            if (i_prev_less) begin
                r_ent  <= i_prev;
                r_slot <= i_prev_slot;
            end else begin
                r_ent  <= i_new;
                r_slot <= i_new_slot;
            end
        end else if (i_op.dec) begin
            r_ent.remaining <= r_ent.remaining - 16'd1;
        end
    end

    assign o_ent   = r_ent;
    assign o_slot  = r_slot;
    assign o_valid = r_valid;

endmodule

FILE: hw/rtl/pps_slot_cell.sv
// One cell of the free slot chain, kept sorted by ascending slot index.
// Depends on pps_pkg for the chain control type.
module pps_slot_cell #(
    parameter int SW    = 5,
    parameter int INDEX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pps_pkg::t_chain_op i_op,
    input  logic [SW-1:0]      i_new_slot,
    input  logic [SW-1:0]      i_prev_slot,
    input  logic               i_prev_valid,
    input  logic               i_prev_less,
    input  logic [SW-1:0]      i_next_slot,
    input  logic               i_next_valid,
    output logic [SW-1:0]      o_slot,
    output logic               o_valid,
    output logic               o_less
);
    import pps_pkg::*;

    logic          r_valid;
    logic [SW-1:0] r_slot;

    assign o_less = !r_valid || (i_new_slot < r_slot);

    // Reset fills the list with every slot in order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b1;
            r_slot  <= SW'(INDEX);
        end else if (i_op.pop) begin
            r_valid <= i_next_valid;
            r_slot  <= i_next_slot;
        end else if (i_op.ins && o_less) begin
            r_valid <= i_prev_less ? i_prev_valid : 1'b1;
            r_slot  <= i_prev_less ? i_prev_slot : i_new_slot;
        end
    end

    assign o_slot  = r_slot;
    assign o_valid = r_valid;

endmodule

FILE: hw/rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler built from two sorted cell chains.
// The result is registered and strobes in the cycle after the request is taken.
// Throughput: one request per cycle; busy never rises, each request completes
// in the cycle it is taken because the job chain head is always the winner.
// Reset: time zero, job chain empty, free slot chain refilled at once.
// The receiver cannot stall; each result shows for exactly one cycle.
module preemptive_priority_scheduler #(
    parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pps_pkg::t_req i_req,
    output logic          o_res_valid,
    output pps_pkg::t_res o_res
);
    import pps_pkg::*;

    localparam int SW = $clog2(MAX_JOBS);

    t_job          job_ent   [MAX_JOBS];
    logic [SW-1:0] job_slot  [MAX_JOBS];
    logic          job_valid [MAX_JOBS];
    logic          job_less  [MAX_JOBS];

    logic [SW-1:0] free_slot  [MAX_JOBS];
    logic          free_valid [MAX_JOBS];
    logic          free_less  [MAX_JOBS];

    logic [31:0] r_time;
    logic [31:0] r_time_next;
    logic        r_res_valid;
    t_res        r_res;

    logic          accept;
    logic          head_done;
    t_chain_op     job_op;
    t_chain_op     head_op;
    t_chain_op     free_op;
    t_job          new_job;
    logic [SW-1:0] new_free;
    t_res          n_res;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign head_done = job_ent[0].remaining == 16'd1;

    always_comb begin
        new_job.prio      = i_req.job_priority;
        new_job.job       = i_req.job_number;
        new_job.remaining = i_req.job_burst;
        new_job.arrival   = r_time;
        new_job.due       = r_time + {16'd0, i_req.job_burst};
        new_free          = job_slot[0];

        job_op  = '0;
        free_op = '0;
        n_res   = '0;

        if (i_req.mode == MODE_ARRIVAL) begin
            if (i_req.job_burst == 16'd0 || !free_valid[0]) begin
                n_res.status = ST_REJECTED;
            end else begin
                n_res.status = ST_ACCEPTED;
                job_op.ins   = accept;
                free_op.pop  = accept;
            end
        end else if (!job_valid[0]) begin
            n_res.status = ST_IDLE;
        end else begin
            n_res.status     = ST_SERVED;
            n_res.served_job = job_ent[0].job;
            job_op.dec       = accept;
            if (head_done) begin
                // retire the head and hand its slot back to the free list
                job_op.pop            = accept;
                free_op.ins           = accept;
                n_res.job_done        = 1'b1;
                n_res.finish_time     = r_time_next;
                n_res.turnaround_time = r_time_next - job_ent[0].arrival;
                n_res.wait_time       = r_time_next - job_ent[0].due;
            end
        end
    end

    // only the head cell counts down
    always_comb begin
        head_op     = job_op;
        head_op.dec = job_op.dec && !job_op.pop;
    end

    for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cells
        t_chain_op cell_op;

        always_comb begin
            cell_op = job_op;
            if (i == 0) begin
                cell_op = head_op;
            end else begin
                cell_op.dec = 1'b0;
            end
        end

        pps_job_cell #(
            .SW (SW)
        ) u_job (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (cell_op),
            .i_new        (new_job),
            .i_new_slot   (free_slot[0]),
            .i_prev       (job_ent[(i == 0) ? 0 : i - 1]),
            .i_prev_slot  (job_slot[(i == 0) ? 0 : i - 1]),
            .i_prev_valid ((i == 0) ? 1'b0 : job_valid[(i == 0) ? 0 : i - 1]),
            .i_prev_less  ((i == 0) ? 1'b0 : job_less[(i == 0) ? 0 : i - 1]),
            .i_next       (job_ent[(i == MAX_JOBS - 1) ? i : i + 1]),
            .i_next_slot  (job_slot[(i == MAX_JOBS - 1) ? i : i + 1]),
            .i_next_valid ((i == MAX_JOBS - 1) ? 1'b0 :
                           job_valid[(i == MAX_JOBS - 1) ? i : i + 1]),
            .o_ent        (job_ent[i]),
            .o_slot       (job_slot[i]),
            .o_valid      (job_valid[i]),
            .o_less       (job_less[i])
        );

        pps_slot_cell #(
            .SW    (SW),
            .INDEX (i)
        ) u_free (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_op         (free_op),
            .i_new_slot   (new_free),
            .i_prev_slot  (free_slot[(i == 0) ? 0 : i - 1]),
            .i_prev_valid ((i == 0) ? 1'b0 : free_valid[(i == 0) ? 0 : i - 1]),
            .i_prev_less  ((i == 0) ? 1'b0 : free_less[(i == 0) ? 0 : i - 1]),
            .i_next_slot  (free_slot[(i == MAX_JOBS - 1) ? i : i + 1]),
            .i_next_valid ((i == MAX_JOBS - 1) ? 1'b0 :
                           free_valid[(i == MAX_JOBS - 1) ? i : i + 1]),
            .o_slot       (free_slot[i]),
            .o_valid      (free_valid[i]),
            .o_less       (free_less[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= 32'd0;
            r_time_next <= 32'd1;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= accept;
            if (accept && i_req.mode == MODE_TICK) begin
                r_time      <= r_time_next;
                r_time_next <= r_time_next + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the preemptive priority scheduler: arrivals and ticks.
// A shadow job table predicts every result, and the results are checked in order.
// Depends on pps_pkg and preemptive_priority_scheduler.
module testbench;

    import pps_pkg::*;

    localparam int SLOTS      = MAX_JOBS_DEF;
    localparam int CYCLE_CAP  = 200000;
    localparam int RAND_ITEMS = 550;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_req i_req   = '0;
    logic o_res_valid;
    t_res o_res;

    preemptive_priority_scheduler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    t_req pending_reqs[$];
    t_res sched_results_due[$];
    int   errors = 0;
    int   cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;

    // shadow job table
    bit          slot_live[SLOTS];
    logic [5:0]  slot_job[SLOTS];
    logic [7:0]  slot_prio[SLOTS];
    logic [15:0] slot_left[SLOTS];
    logic [15:0] slot_len[SLOTS];
    logic [31:0] slot_start[SLOTS];
    logic [31:0] now_ticks;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic void queue_req(t_req r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic t_req make_req(logic m, logic [5:0] j, logic [15:0] b, logic [7:0] p);
        t_req r;
        r.mode         = m;
        r.job_number   = j;
        r.job_burst    = b;
        r.job_priority = p;
        return r;
    endfunction

    function automatic t_req tick_req();
        return make_req(MODE_TICK, 6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                        8'($urandom_range(0, 255)));
    endfunction

    function automatic t_req random_arrival();
        int          pick;
        int          spread;
        logic [5:0]  j;
        logic [15:0] b;
        logic [7:0]  p;
        j = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(1, 32)) : 6'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        spread = $urandom_range(0, 9);
        if (pick < 5)
            b = 16'd0;
        else if (pick < 75)
            b = 16'($urandom_range(1, 4));
        else if (pick < 98)
            b = 16'($urandom_range(1, 24));
        else
            b = 16'($urandom_range(0, 65535));
        // keep long jobs at the back so they do not starve the table
        if (pick >= 98)
            p = 8'($urandom_range(192, 255));
        else if (spread < 4)
            p = 8'($urandom_range(0, 7));
        else if (spread < 8)
            p = 8'($urandom_range(0, 127));
        else
            p = 8'($urandom_range(0, 255));
        return make_req(MODE_ARRIVAL, j, b, p);
    endfunction

    task automatic schedule_request(input t_req r, output t_res res);
        int          free_idx;
        int          pick;
        logic [31:0] fin;
        res = '0;
        if (r.mode == MODE_ARRIVAL) begin
            free_idx = -1;
            for (int s = SLOTS - 1; s >= 0; s--)
                if (!slot_live[s]) free_idx = s;
            if (r.job_burst == 16'd0 || free_idx < 0) begin
                res.status = ST_REJECTED;
            end else begin
                slot_live[free_idx]  = 1'b1;
                slot_job[free_idx]   = r.job_number;
                slot_prio[free_idx]  = r.job_priority;
                slot_left[free_idx]  = r.job_burst;
                slot_len[free_idx]   = r.job_burst;
                slot_start[free_idx] = now_ticks;
                res.status = ST_ACCEPTED;
            end
        end else begin
            pick = -1;
            // strict compares keep the lowest slot on a full tie
            for (int s = 0; s < SLOTS; s++)
                if (slot_live[s] && (pick < 0 || slot_prio[s] < slot_prio[pick] ||
                    (slot_prio[s] == slot_prio[pick] && slot_job[s] < slot_job[pick])))
                    pick = s;
            if (pick < 0) begin
                res.status = ST_IDLE;
            end else begin
                res.status     = ST_SERVED;
                res.served_job = slot_job[pick];
                slot_left[pick] = slot_left[pick] - 16'd1;
                if (slot_left[pick] == 16'd0) begin
                    fin = now_ticks + 32'd1;
                    res.job_done        = 1'b1;
                    res.finish_time     = fin;
                    res.turnaround_time = fin - slot_start[pick];
                    res.wait_time       = fin - slot_start[pick] - {16'd0, slot_len[pick]};
                    slot_live[pick] = 1'b0;
                end
            end
            now_ticks = now_ticks + 32'd1;
        end
    endtask

    task automatic note_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
        errors++;
        if (errors <= 10)
            $display("mismatch in %s at cycle %0d: expected %0h, got %0h",
                     what, cycles, want_v, got_v);
    endtask

    // driver: bursts of requests separated by random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (start) void'(pending_reqs.pop_front());
            if (gap_left != 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                i_req <= pending_reqs[0];
                start <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check the result first, then predict for the request taken here
    always @(posedge i_clk) begin
        t_res want;
        t_res next_res;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) slot_live[s] = 1'b0;
            now_ticks = '0;
        end else begin
            if (o_res_valid !== 1'b0) begin
                if (sched_results_due.size() == 0) begin
                    note_mismatch("result with nothing pending, status", '0,
                                  32'(o_res.status));
                end else begin
                    want = sched_results_due.pop_front();
                    if (o_res.status !== want.status)
                        note_mismatch("status", 32'(want.status), 32'(o_res.status));
                    if (o_res.served_job !== want.served_job)
                        note_mismatch("served_job", 32'(want.served_job),
                                      32'(o_res.served_job));
                    if (o_res.job_done !== want.job_done)
                        note_mismatch("job_done", 32'(want.job_done), 32'(o_res.job_done));
                    if (o_res.finish_time !== want.finish_time)
                        note_mismatch("finish_time", want.finish_time,
                                      o_res.finish_time);
                    if (o_res.turnaround_time !== want.turnaround_time)
                        note_mismatch("turnaround_time", want.turnaround_time,
                                      o_res.turnaround_time);
                    if (o_res.wait_time !== want.wait_time)
                        note_mismatch("wait_time", want.wait_time, o_res.wait_time);
                end
            end
            if (start && !busy) begin
                schedule_request(i_req, next_res);
                sched_results_due = {sched_results_due, next_res};
            end
        end
    end

    initial begin
        int seg_len;
        int arr_pct;
        int n;
        // empty table, zero burst, a one-tick job
        queue_req(tick_req());
        queue_req(make_req(MODE_ARRIVAL, 6'd7, 16'd0, 8'd3));
        queue_req(make_req(MODE_ARRIVAL, 6'd0, 16'd1, 8'd0));
        queue_req(tick_req());
        // longest burst at the lowest rank, then ties on priority and on job number
        queue_req(make_req(MODE_ARRIVAL, 6'd63, 16'hFFFF, 8'hFF));
        queue_req(make_req(MODE_ARRIVAL, 6'd5, 16'd2, 8'd10));
        queue_req(make_req(MODE_ARRIVAL, 6'd3, 16'd2, 8'd10));
        queue_req(make_req(MODE_ARRIVAL, 6'd3, 16'd1, 8'd10));
        queue_req(make_req(MODE_ARRIVAL, 6'd32, 16'd3, 8'h80));
        queue_req(make_req(MODE_ARRIVAL, 6'd42, 16'hAAAA, 8'h55));
        queue_req(tick_req());
        queue_req(tick_req());
        queue_req(tick_req());
        // preempt with a more urgent job
        queue_req(make_req(MODE_ARRIVAL, 6'd9, 16'd2, 8'd1));
        repeat (10) queue_req(tick_req());

        // segments swing between filling and draining the table
        n = 0;
        while (n < RAND_ITEMS) begin
            seg_len = $urandom_range(15, 60);
            case ($urandom_range(0, 3))
                0: arr_pct = 15;
                1: arr_pct = 50;
                2: arr_pct = 80;
                default: arr_pct = 95;
            endcase
            repeat (seg_len) begin
                if ($urandom_range(0, 99) < arr_pct)
                    queue_req(random_arrival());
                else
                    queue_req(tick_req());
                n++;
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || start || sched_results_due.size() != 0);
        repeat (4) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
